FILE: sv/u2e_pkg.sv
// Shared types, constants and helpers for the UTF-8 to backslash-u escape encoder.
package u2e_pkg;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_TERM = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_BSL  = 3'd0;
   localparam step_type STEP_U    = 3'd1;
   localparam step_type STEP_HEX3 = 3'd2;
   localparam step_type STEP_HEX2 = 3'd3;
   localparam step_type STEP_HEX1 = 3'd4;
   localparam step_type STEP_HEX0 = 3'd5;
   localparam step_type STEP_TERM = 3'd6;

   localparam logic [7:0] CHAR_BSL = 8'h5c;
   localparam logic [7:0] CHAR_U   = 8'h75;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   typedef struct packed {
      logic [1:0]  pend;
      logic [15:0] partial;
      logic        drop;
   } state_type;

   typedef struct packed {
      logic        valid;
      logic        err;
      logic        term;
      logic [15:0] code;
   } job_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = 8'h30 + {4'd0, v};
      end else begin
         r = 8'h57 + {4'd0, v};
      end
      return r;
   endfunction

endpackage

FILE: sv/utf8_to_unicode_escape.sv
// Top level: UTF-8 byte stream in, backslash-u escape characters out.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  req     | req_valid/req_stall  | req_in_byte, req_end_of_string
//  rsp     | rsp_valid/rsp_stall  | rsp_out_char, rsp_result_kind, rsp_last_of_run
//
// One response leaves per cycle from the result register unless rsp is stalled; the
// single-character emitter sends backslash, u and four hex digits per code point,
// with a terminator at end of string. Continuation bytes and dropped bytes pass the
// input register at one per cycle while no escape is being emitted.
// Reset is synchronous and clears the decoder state and all valid flags.
// A stall on rsp holds the result register and backs up into req_stall.
module utf8_to_unicode_escape (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic [1:0] rsp_result_kind,
   output logic       rsp_last_of_run
);
   import u2e_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;

   state_type  state_ff, state_in;
   job_type    dec_job;

   job_type    job_ff;
   step_type   step_ff, step_in;
   logic       job_valid_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff;
   kind_type   rsp_kind_ff;
   logic       rsp_last_ff;

   logic       rsp_free, emit, is_last, job_done, consume;
   logic [7:0] emit_char;
   kind_type   emit_kind;

   u2e_decode u_decode (
      .in_eos  (in_eos_ff),
      .in_byte (in_byte_ff),
      .cur     (state_ff),
      .nxt     (state_in),
      .job     (dec_job)
   );

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = job_ff.valid && rsp_free;
   assign is_last   = job_ff.err || (job_ff.term ? (step_ff == STEP_TERM)
                                                 : (step_ff == STEP_HEX0));
   assign job_done  = emit && is_last;
   assign consume   = in_valid_ff && (!job_ff.valid || job_done);
   assign req_stall = in_valid_ff && !consume;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_comb begin
      emit_kind = job_ff.err ? KIND_ERR : KIND_CHAR;
      unique case (step_ff)
         STEP_BSL:  emit_char = job_ff.err ? CHAR_NUL : CHAR_BSL;
         STEP_U:    emit_char = CHAR_U;
         STEP_HEX3: emit_char = hex_digit(job_ff.code[15:12]);
         STEP_HEX2: emit_char = hex_digit(job_ff.code[11:8]);
         STEP_HEX1: emit_char = hex_digit(job_ff.code[7:4]);
         STEP_HEX0: emit_char = hex_digit(job_ff.code[3:0]);
         STEP_TERM: begin
            emit_char = CHAR_NUL;
            emit_kind = KIND_TERM;
         end
         default:   emit_char = CHAR_NUL;
      endcase
   end

   always_comb begin
      job_valid_in = job_ff.valid;
      step_in      = step_ff;
      if (consume && dec_job.valid) begin
         job_valid_in = 1'b1;
         step_in      = STEP_BSL;
      end else if (job_done) begin
         job_valid_in = 1'b0;
      end else if (emit) begin
         step_in = step_ff + 3'd1;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         job_ff.valid <= 1'b0;
         step_ff      <= STEP_BSL;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         job_ff.valid <= job_valid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (consume) begin
            state_ff <= state_in;
         end
         if (consume && dec_job.valid) begin
            job_ff.err  <= dec_job.err;
            job_ff.term <= dec_job.term;
            job_ff.code <= dec_job.code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_in_byte;
         in_eos_ff  <= req_end_of_string;
      end
      if (emit) begin
         rsp_char_ff <= emit_char;
         rsp_kind_ff <= emit_kind;
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

FILE: sv/u2e_decode.sv
// Byte decoder: gathers UTF-8 sequences into code points and produces the next job.
module u2e_decode (
   input  logic               in_eos,
   input  logic [7:0]         in_byte,
   input  u2e_pkg::state_type cur,
   output u2e_pkg::state_type nxt,
   output u2e_pkg::job_type   job
);
   import u2e_pkg::*;

   logic        done;
   logic [15:0] code;

   always_comb begin
      nxt  = cur;
      job  = '0;
      done = 1'b0;
      code = cur.partial;
      if (cur.drop) begin
         if (in_eos) begin
            nxt = '0;
         end
      end else begin
         if (cur.pend == 2'd0) begin
            priority if (in_byte[7] == 1'b0) begin
               code = {8'd0, in_byte};
               done = 1'b1;
            end else if (in_byte[7:5] == 3'b110) begin
               nxt.partial = {11'd0, in_byte[4:0]};
               nxt.pend    = 2'd1;
            end else if (in_byte[7:4] == 4'b1110) begin
               nxt.partial = {12'd0, in_byte[3:0]};
               nxt.pend    = 2'd2;
            end else begin
               nxt       = '0;
               nxt.drop  = ~in_eos;
               job.valid = 1'b1;
               job.err   = 1'b1;
            end
         end else begin
            code        = {cur.partial[9:0], in_byte[5:0]};
            nxt.partial = code;
            nxt.pend    = cur.pend - 2'd1;
            done        = (cur.pend == 2'd1);
         end
         if (done) begin
            nxt.partial = '0;
            job.valid   = 1'b1;
            job.term    = in_eos;
            job.code    = code;
            if (in_eos) begin
               nxt = '0;
            end
         end else if (in_eos && !job.err) begin
            nxt       = '0;
            job.valid = 1'b1;
            job.err   = 1'b1;
         end
      end
   end

endmodule

FILE: sv/u2e_check.sv
// Port-level checker for the escape encoder, bound to the top level.
module u2e_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       req_end_of_string,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_char,
   input logic [1:0] rsp_result_kind,
   input logic       rsp_last_of_run
);
   import u2e_pkg::*;

   logic rsp_take;
   assign rsp_take = rsp_valid && !rsp_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char)
         && $stable(rsp_result_kind) && $stable(rsp_last_of_run))
      else $error("stalled response changed");

   a_term_form: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_result_kind == KIND_TERM |-> rsp_last_of_run && rsp_out_char == CHAR_NUL)
      else $error("terminator not last or not zero");

   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_result_kind == KIND_ERR |-> rsp_last_of_run && rsp_out_char == CHAR_NUL)
      else $error("error result not last or not zero");

   a_bsl_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_result_kind == KIND_CHAR && rsp_out_char == CHAR_BSL |-> !rsp_last_of_run)
      else $error("escape ended at backslash");

endmodule

bind utf8_to_unicode_escape u2e_check u_check (.*);
